// ===== rtl/acd_pkg.sv =====
// shared constants, types and helpers for the ac contact detector
`default_nettype none

package acd_pkg;

    localparam int ADC_BITS   = 8;
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 8;

    // op codes of an input word
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CROSS  = 2'd1;
    localparam logic [1:0] OP_TAKE   = 2'd2;
    localparam logic [1:0] OP_SOFT   = 2'd3;

    // mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CAND = 2'd1;
    localparam logic [1:0] MODE_LOCK = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RATIO_NUM   = 3'd0;
    localparam logic [2:0] REG_RATIO_DEN   = 3'd1;
    localparam logic [2:0] REG_MIN_DIFF    = 3'd2;
    localparam logic [2:0] REG_BASE_SHIFT  = 3'd3;
    localparam logic [2:0] REG_CENTER_SHIFT = 3'd4;
    localparam logic [2:0] REG_DETECT_NEED = 3'd5;
    localparam logic [2:0] REG_RELEASE_NEED = 3'd6;
    localparam logic [2:0] REG_MAX_SAMPLES = 3'd7;

    // register reset values
    localparam logic [7:0] RST_RATIO_NUM    = 8'd3;
    localparam logic [7:0] RST_RATIO_DEN    = 8'd2;
    localparam logic [7:0] RST_MIN_DIFF     = 8'd4;
    localparam logic [2:0] RST_BASE_SHIFT   = 3'd3;
    localparam logic [2:0] RST_CENTER_SHIFT = 3'd4;
    localparam logic [7:0] RST_DETECT_NEED  = 8'd2;
    localparam logic [7:0] RST_RELEASE_NEED = 8'd3;
    localparam logic [7:0] RST_MAX_SAMPLES  = 8'd64;

    // state reset values
    localparam logic [ADC_BITS-1:0] RST_CENTER   = 8'd128;
    localparam logic [7:0]          RST_BASELINE = 8'd10;
    localparam logic [7:0]          BASE_FLOOR   = 8'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // move cur toward target by the difference shifted right, rounding down
    function automatic logic [7:0] shift_track(input logic [7:0] cur,
                                               input logic [7:0] target,
                                               input logic [2:0] sh);
        logic signed [8:0] d;
        logic signed [8:0] step;
        d = $signed({1'b0, target}) - $signed({1'b0, cur});
        step = d >>> sh;
        return cur + step[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/acd_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module acd_div #(
    parameter int DIVIDEND_W = acd_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = acd_pkg::DIVISOR_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0]      quotient,
    output acd_pkg::div_status_t       status
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        ge        = rem_shift >= {1'b0, dsr_reg};
        rem_next  = ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        quo_next  = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/ac_contact_detector_unit.sv =====
// ac contact detector top level: sample averaging, half-cycle mean, contact machine
//
// input channel (in_valid/in_ready) takes one word: op and an 8-bit adc sample.
// output channel (out_valid/out_ready) returns one word per input word with the
// trigger flags, mode, last half mean, baseline and dc center after that word.
// configuration is a plain write port (wr_en, wr_index, wr_data), taken at once.
// one word is worked on at a time; in_ready is high only between words.
// a counted sample passes through the center and deviation states before out_valid
// rises; consume, soft reset, a dropped sample or a crossing with no samples go
// straight to the output state; a zero crossing that closes a half with samples
// waits for the mean division, the threshold division and the decision first.
// such a crossing uses the shared 16-step divider, once for the mean
// and once for the ratio threshold.
// the result sits in an output register, so a stalled receiver holds only
// that word; the next word is accepted, and it waits at the end of its work
// until the output register is free.
// reset clears mode, counters, sums and trigger, sets center to 128, baseline
// to 10 and the registers to their defaults.
`default_nettype none

module ac_contact_detector_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [2:0] wr_index,
    input  wire logic [7:0] wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [7:0] sample,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            trigger_taken,
    output logic            trigger_pending,
    output logic [1:0]      mode,
    output logic [7:0]      half_mean,
    output logic [7:0]      baseline_level,
    output logic [7:0]      dc_center
);

    localparam int DW = acd_pkg::DIVIDEND_W;
    localparam int SW = acd_pkg::DIVISOR_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENTER = 3'd1;
    localparam logic [2:0] ST_DEV    = 3'd2;
    localparam logic [2:0] ST_MEAN   = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_THR    = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // configuration
    logic [7:0] ratio_num_reg;
    logic [7:0] ratio_den_reg;
    logic [7:0] min_diff_reg;
    logic [2:0] base_shift_reg;
    logic [2:0] center_shift_reg;
    logic [7:0] detect_need_reg;
    logic [7:0] release_need_reg;
    logic [7:0] max_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_num_reg    <= acd_pkg::RST_RATIO_NUM;
            ratio_den_reg    <= acd_pkg::RST_RATIO_DEN;
            min_diff_reg     <= acd_pkg::RST_MIN_DIFF;
            base_shift_reg   <= acd_pkg::RST_BASE_SHIFT;
            center_shift_reg <= acd_pkg::RST_CENTER_SHIFT;
            detect_need_reg  <= acd_pkg::RST_DETECT_NEED;
            release_need_reg <= acd_pkg::RST_RELEASE_NEED;
            max_samples_reg  <= acd_pkg::RST_MAX_SAMPLES;
        end
        else if (wr_en)
        begin
            case (wr_index)
                acd_pkg::REG_RATIO_NUM:    ratio_num_reg    <= wr_data;
                acd_pkg::REG_RATIO_DEN:    ratio_den_reg    <= wr_data;
                acd_pkg::REG_MIN_DIFF:     min_diff_reg     <= wr_data;
                acd_pkg::REG_BASE_SHIFT:   base_shift_reg   <= wr_data[2:0];
                acd_pkg::REG_CENTER_SHIFT: center_shift_reg <= wr_data[2:0];
                acd_pkg::REG_DETECT_NEED:  detect_need_reg  <= wr_data;
                acd_pkg::REG_RELEASE_NEED: release_need_reg <= wr_data;
                acd_pkg::REG_MAX_SAMPLES:  max_samples_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    // detector state
    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  center_reg, center_next;
    logic [7:0]  baseline_reg, baseline_next;
    logic [15:0] dev_sum_reg, dev_sum_next;
    logic [7:0]  sample_cnt_reg, sample_cnt_next;
    logic [7:0]  mean_reg, mean_next;
    logic [7:0]  detect_cnt_reg, detect_cnt_next;
    logic [7:0]  release_cnt_reg, release_cnt_next;
    logic        half_open_reg, half_open_next;
    logic        trigger_reg, trigger_next;
    logic        taken_reg, taken_next;
    logic        contact_reg, contact_next;
    logic [7:0]  sample_reg, sample_next;

    // output word register
    logic        out_valid_reg, out_valid_next;
    logic        out_taken_reg;
    logic        out_pending_reg;
    logic [1:0]  out_mode_reg;
    logic [7:0]  out_mean_reg;
    logic [7:0]  out_base_reg;
    logic [7:0]  out_center_reg;
    logic        out_load;

    // shared divider
    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [SW-1:0]        div_divisor;
    logic [DW-1:0]        div_quotient;
    acd_pkg::div_status_t div_status;

    logic [15:0] product;
    logic [7:0]  den_eff;
    logic [7:0]  dev_abs;
    logic [8:0]  dev_diff;
    logic [7:0]  base_track;
    logic [7:0]  base_tracked;
    logic [7:0]  detect_inc;
    logic [7:0]  release_inc;
    logic        accept;

    acd_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign product  = 16'(ratio_num_reg) * 16'(baseline_reg);
    assign den_eff  = (ratio_den_reg == 8'd0) ? 8'd1 : ratio_den_reg;

    always_comb
    begin
        dev_diff = {1'b0, sample_reg} - {1'b0, center_reg};
        dev_abs  = dev_diff[8] ? 8'(-dev_diff) : dev_diff[7:0];
        base_track = acd_pkg::shift_track(baseline_reg, mean_reg, base_shift_reg);
        base_tracked = (base_track == 8'd0) ? acd_pkg::BASE_FLOOR : base_track;
        detect_inc  = detect_cnt_reg + 8'd1;
        release_inc = release_cnt_reg + 8'd1;
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        center_next      = center_reg;
        baseline_next    = baseline_reg;
        dev_sum_next     = dev_sum_reg;
        sample_cnt_next  = sample_cnt_reg;
        mean_next        = mean_reg;
        detect_cnt_next  = detect_cnt_reg;
        release_cnt_next = release_cnt_reg;
        half_open_next   = half_open_reg;
        trigger_next     = trigger_reg;
        taken_next       = taken_reg;
        contact_next     = contact_reg;
        sample_next      = sample_reg;
        div_start        = 1'b0;
        div_dividend     = product;
        div_divisor      = den_eff;
        out_load         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    taken_next  = 1'b0;
                    sample_next = sample;
                    state_next  = ST_OUT;
                    case (op)
                        acd_pkg::OP_SAMPLE:
                        begin
                            if (half_open_reg && (sample_cnt_reg < max_samples_reg))
                            begin
                                state_next = ST_CENTER;
                            end
                        end
                        acd_pkg::OP_CROSS:
                        begin
                            if (half_open_reg && (sample_cnt_reg != 8'd0))
                            begin
                                div_start    = 1'b1;
                                div_dividend = dev_sum_reg;
                                div_divisor  = sample_cnt_reg;
                                state_next   = ST_MEAN;
                            end
                            dev_sum_next    = '0;
                            sample_cnt_next = '0;
                            half_open_next  = 1'b1;
                        end
                        acd_pkg::OP_TAKE:
                        begin
                            taken_next   = trigger_reg;
                            trigger_next = 1'b0;
                        end
                        default:
                        begin
                            mode_next        = acd_pkg::MODE_IDLE;
                            dev_sum_next     = '0;
                            sample_cnt_next  = '0;
                            mean_next        = '0;
                            detect_cnt_next  = '0;
                            release_cnt_next = '0;
                            half_open_next   = 1'b0;
                            trigger_next     = 1'b0;
                        end
                    endcase
                end
            end
            ST_CENTER:
            begin
                center_next = acd_pkg::shift_track(center_reg, sample_reg, center_shift_reg);
                state_next  = ST_DEV;
            end
            ST_DEV:
            begin
                dev_sum_next    = dev_sum_reg + 16'(dev_abs);
                sample_cnt_next = sample_cnt_reg + 8'd1;
                state_next      = ST_OUT;
            end
            ST_MEAN:
            begin
                if (div_status.done)
                begin
                    mean_next  = div_quotient[7:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_THR;
            end
            ST_THR:
            begin
                if (div_status.done)
                begin
                    contact_next = (16'(mean_reg) > div_quotient) &&
                                   ({1'b0, mean_reg} > ({1'b0, baseline_reg} + {1'b0, min_diff_reg}));
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_OUT;
                case (mode_reg)
                    acd_pkg::MODE_CAND:
                    begin
                        if (contact_reg)
                        begin
                            detect_cnt_next = detect_inc;
                            if (detect_inc >= detect_need_reg)
                            begin
                                trigger_next = 1'b1;
                                mode_next    = acd_pkg::MODE_LOCK;
                            end
                        end
                        else
                        begin
                            release_cnt_next = release_inc;
                            if (release_inc >= release_need_reg)
                            begin
                                detect_cnt_next  = '0;
                                release_cnt_next = '0;
                                mode_next        = acd_pkg::MODE_IDLE;
                                baseline_next    = base_tracked;
                            end
                        end
                    end
                    acd_pkg::MODE_LOCK:
                    begin
                        if (contact_reg)
                        begin
                            release_cnt_next = '0;
                        end
                        else
                        begin
                            release_cnt_next = release_inc;
                            if (release_inc >= release_need_reg)
                            begin
                                detect_cnt_next  = '0;
                                release_cnt_next = '0;
                                mode_next        = acd_pkg::MODE_IDLE;
                                baseline_next    = base_tracked;
                            end
                        end
                    end
                    default:
                    begin
                        if (contact_reg)
                        begin
                            detect_cnt_next  = 8'd1;
                            release_cnt_next = '0;
                            mode_next        = acd_pkg::MODE_CAND;
                        end
                        else
                        begin
                            baseline_next = base_tracked;
                        end
                    end
                endcase
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= acd_pkg::MODE_IDLE;
            center_reg      <= acd_pkg::RST_CENTER;
            baseline_reg    <= acd_pkg::RST_BASELINE;
            dev_sum_reg     <= '0;
            sample_cnt_reg  <= '0;
            mean_reg        <= '0;
            detect_cnt_reg  <= '0;
            release_cnt_reg <= '0;
            half_open_reg   <= 1'b0;
            trigger_reg     <= 1'b0;
            taken_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            center_reg      <= center_next;
            baseline_reg    <= baseline_next;
            dev_sum_reg     <= dev_sum_next;
            sample_cnt_reg  <= sample_cnt_next;
            mean_reg        <= mean_next;
            detect_cnt_reg  <= detect_cnt_next;
            release_cnt_reg <= release_cnt_next;
            half_open_reg   <= half_open_next;
            trigger_reg     <= trigger_next;
            taken_reg       <= taken_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        contact_reg <= contact_next;
        sample_reg  <= sample_next;
        if (out_load)
        begin
            out_taken_reg   <= taken_reg;
            out_pending_reg <= trigger_reg;
            out_mode_reg    <= mode_reg;
            out_mean_reg    <= mean_reg;
            out_base_reg    <= baseline_reg;
            out_center_reg  <= center_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign trigger_taken   = out_taken_reg;
    assign trigger_pending = out_pending_reg;
    assign mode            = out_mode_reg;
    assign half_mean       = out_mean_reg;
    assign baseline_level  = out_base_reg;
    assign dc_center       = out_center_reg;

    // baseline floor holds at all times
    assert property (@(posedge clk) disable iff (!rst_n) baseline_reg != 8'd0)
        else $error("baseline dropped to zero");

    // trigger is only raised on entering lockout
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(trigger_reg) |-> (mode_reg == acd_pkg::MODE_LOCK))
        else $error("trigger set outside lockout");

    // divider never restarted while running
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // an accepted word always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> (state_reg != ST_IDLE))
        else $error("accepted word not processed");

    // samples only counted inside an open half
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_cnt_reg != 8'd0) |-> half_open_reg)
        else $error("sample count without open half");

endmodule

`default_nettype wire

// ===== dv/ac_contact_detector_checker.sv =====
// checker for the ac contact detector: predicts each status word and compares it
`timescale 1ns / 100ps

module ac_contact_detector_checker
    import acd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [7:0] wr_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] sample,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       trigger_taken,
    input  logic       trigger_pending,
    input  logic [1:0] mode,
    input  logic [7:0] half_mean,
    input  logic [7:0] baseline_level,
    input  logic [7:0] dc_center,
    output int         outstanding,
    output int         fail_count
);

    typedef struct packed {
        logic       taken;
        logic       pending;
        logic [1:0] mode;
        logic [7:0] mean;
        logic [7:0] baseline;
        logic [7:0] center;
    } status_t;

    logic [7:0] cfg_ratio_num;
    logic [7:0] cfg_ratio_den;
    logic [7:0] cfg_min_diff;
    logic [2:0] cfg_base_shift;
    logic [2:0] cfg_center_shift;
    logic [7:0] cfg_detect_need;
    logic [7:0] cfg_release_need;
    logic [7:0] cfg_max_samples;

    logic [1:0]  st_mode;
    logic [7:0]  st_center;
    logic [7:0]  st_baseline;
    logic [15:0] st_dev_sum;
    logic [7:0]  st_count;
    logic [7:0]  st_mean;
    logic [7:0]  st_detect_cnt;
    logic [7:0]  st_release_cnt;
    logic        st_half_open;
    logic        st_trigger;

    status_t expected_status_q[$];

    initial fail_count = 0;

    function automatic logic [7:0] track_toward(input logic [7:0] cur,
                                                input logic [7:0] target,
                                                input logic [2:0] sh);
        int diff;
        diff = int'(target) - int'(cur);
        return 8'(int'(cur) + (diff >>> sh));
    endfunction

    function automatic bit contact_seen(input logic [7:0] f);
        int den;
        int thr;
        den = (cfg_ratio_den == 8'd0) ? 1 : int'(cfg_ratio_den);
        thr = int'(st_baseline) * int'(cfg_ratio_num) / den;
        return (int'(f) > thr) && (int'(f) > int'(st_baseline) + int'(cfg_min_diff));
    endfunction

    function automatic void follow_baseline(input logic [7:0] f);
        st_baseline = track_toward(st_baseline, f, cfg_base_shift);
        if (st_baseline == 8'd0)
            st_baseline = BASE_FLOOR;
    endfunction

    function automatic void count_release();
        st_release_cnt = st_release_cnt + 8'd1;
        if (st_release_cnt >= cfg_release_need)
        begin
            st_detect_cnt  = 8'd0;
            st_release_cnt = 8'd0;
            st_mode        = MODE_IDLE;
            follow_baseline(st_mean);
        end
    endfunction

    function automatic void clear_soft();
        st_mode        = MODE_IDLE;
        st_dev_sum     = 16'd0;
        st_count       = 8'd0;
        st_mean        = 8'd0;
        st_detect_cnt  = 8'd0;
        st_release_cnt = 8'd0;
        st_half_open   = 1'b0;
        st_trigger     = 1'b0;
    endfunction

    function automatic void take_sample(input logic [7:0] raw);
        int dev;
        if (!st_half_open || st_count >= cfg_max_samples)
            return;
        st_center = track_toward(st_center, raw, cfg_center_shift);
        dev = int'(raw) - int'(st_center);
        if (dev < 0)
            dev = -dev;
        st_dev_sum = st_dev_sum + 16'(dev);
        st_count   = st_count + 8'd1;
    endfunction

    function automatic void close_half();
        bit have_mean;
        have_mean = st_half_open && (st_count != 8'd0);
        if (have_mean)
            st_mean = 8'(st_dev_sum / st_count);
        st_dev_sum   = 16'd0;
        st_count     = 8'd0;
        st_half_open = 1'b1;
        if (!have_mean)
            return;
        if (st_mode == MODE_CAND)
        begin
            if (contact_seen(st_mean))
            begin
                st_detect_cnt = st_detect_cnt + 8'd1;
                if (st_detect_cnt >= cfg_detect_need)
                begin
                    st_trigger = 1'b1;
                    st_mode    = MODE_LOCK;
                end
            end
            else
                count_release();
        end
        else if (st_mode == MODE_LOCK)
        begin
            if (contact_seen(st_mean))
                st_release_cnt = 8'd0;
            else
                count_release();
        end
        else
        begin
            if (contact_seen(st_mean))
            begin
                st_detect_cnt  = 8'd1;
                st_release_cnt = 8'd0;
                st_mode        = MODE_CAND;
            end
            else
                follow_baseline(st_mean);
        end
    endfunction

    function automatic status_t predict_status(input logic [1:0] code,
                                               input logic [7:0] raw);
        status_t r;
        r = '0;
        case (code)
            OP_SAMPLE: take_sample(raw);
            OP_CROSS:  close_half();
            OP_TAKE:
            begin
                r.taken    = st_trigger;
                st_trigger = 1'b0;
            end
            default:   clear_soft();
        endcase
        r.pending  = st_trigger;
        r.mode     = st_mode;
        r.mean     = st_mean;
        r.baseline = st_baseline;
        r.center   = st_center;
        return r;
    endfunction

    function automatic void apply_write(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            REG_RATIO_NUM:    cfg_ratio_num    = val;
            REG_RATIO_DEN:    cfg_ratio_den    = val;
            REG_MIN_DIFF:     cfg_min_diff     = val;
            REG_BASE_SHIFT:   cfg_base_shift   = val[2:0];
            REG_CENTER_SHIFT: cfg_center_shift = val[2:0];
            REG_DETECT_NEED:  cfg_detect_need  = val;
            REG_RELEASE_NEED: cfg_release_need = val;
            default:          cfg_max_samples  = val;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        status_t want;
        status_t got;
        if (!rst_n)
        begin
            cfg_ratio_num    = RST_RATIO_NUM;
            cfg_ratio_den    = RST_RATIO_DEN;
            cfg_min_diff     = RST_MIN_DIFF;
            cfg_base_shift   = RST_BASE_SHIFT;
            cfg_center_shift = RST_CENTER_SHIFT;
            cfg_detect_need  = RST_DETECT_NEED;
            cfg_release_need = RST_RELEASE_NEED;
            cfg_max_samples  = RST_MAX_SAMPLES;
            clear_soft();
            st_center   = RST_CENTER;
            st_baseline = RST_BASELINE;
            expected_status_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (wr_en)
                apply_write(wr_index, wr_data);
            if (out_valid && out_ready)
            begin
                got = {trigger_taken, trigger_pending, mode, half_mean,
                       baseline_level, dc_center};
                if (expected_status_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: status word with none expected: %p", $time, got);
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (got.taken !== want.taken || got.pending !== want.pending ||
                        got.mode !== want.mode || got.mean !== want.mean ||
                        got.baseline !== want.baseline || got.center !== want.center)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: status mismatch: expected %p, got %p",
                                     $time, want, got);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_status_q.push_back(predict_status(op, sample));
            outstanding <= expected_status_q.size();
        end
    end

endmodule

// ===== dv/ac_contact_detector_unit_tb.sv =====
// testbench top for the ac contact detector: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module ac_contact_detector_unit_tb;
    import acd_pkg::*;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       wr_en     = 1'b0;
    logic [2:0] wr_index  = REG_RATIO_NUM;
    logic [7:0] wr_data   = 8'd0;
    logic       in_valid  = 1'b0;
    logic [1:0] op        = OP_SAMPLE;
    logic [7:0] sample    = 8'd0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       trigger_taken;
    logic       trigger_pending;
    logic [1:0] mode;
    logic [7:0] half_mean;
    logic [7:0] baseline_level;
    logic [7:0] dc_center;

    int outstanding;
    int fail_count;
    int words_sent  = 0;
    int burst_left  = 0;
    int max_per_half = 64;
    bit long_hold_req = 1'b0;

    ac_contact_detector_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .trigger_taken   (trigger_taken),
        .trigger_pending (trigger_pending),
        .mode            (mode),
        .half_mean       (half_mean),
        .baseline_level  (baseline_level),
        .dc_center       (dc_center)
    );

    ac_contact_detector_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .trigger_taken   (trigger_taken),
        .trigger_pending (trigger_pending),
        .mode            (mode),
        .half_mean       (half_mean),
        .baseline_level  (baseline_level),
        .dc_center       (dc_center),
        .outstanding     (outstanding),
        .fail_count      (fail_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: changing stall patterns plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int pattern;
        int pattern_left;
        int tick;
        hold_left    = 0;
        pattern      = 0;
        pattern_left = 0;
        tick         = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            tick++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = 400;
            end
            if (pattern_left == 0)
            begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (pattern)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((tick % 3) != 0);
                endcase
        end
    end

    task automatic send_word(input logic [1:0] code, input logic [7:0] raw);
        int gap;
        in_valid <= 1'b1;
        op       <= code;
        sample   <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] num, input logic [7:0] den,
                              input logic [7:0] diff, input logic [7:0] bsh,
                              input logic [7:0] csh, input logic [7:0] det,
                              input logic [7:0] rel, input logic [7:0] maxs);
        write_reg(REG_RATIO_NUM, num);
        write_reg(REG_RATIO_DEN, den);
        write_reg(REG_MIN_DIFF, diff);
        write_reg(REG_BASE_SHIFT, bsh);
        write_reg(REG_CENTER_SHIFT, csh);
        write_reg(REG_DETECT_NEED, det);
        write_reg(REG_RELEASE_NEED, rel);
        write_reg(REG_MAX_SAMPLES, maxs);
        wr_en <= 1'b0;
        max_per_half = maxs;
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_end;
        int loud_left;
        bit loud;
        bit positive;
        int amp;
        int n;
        int dev;
        int level;
        loud_left = 0;
        loud      = 1'b0;
        positive  = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // samples before any crossing, empty half, loud halves to lockout, takes and a soft reset
        send_word(OP_SAMPLE, 8'd0);
        send_word(OP_SAMPLE, 8'd255);
        send_word(OP_CROSS, 8'd0);
        send_word(OP_CROSS, 8'd255);
        send_word(OP_SAMPLE, 8'd255);
        send_word(OP_SAMPLE, 8'd0);
        send_word(OP_SAMPLE, 8'd255);
        send_word(OP_SAMPLE, 8'd0);
        send_word(OP_CROSS, 8'd0);
        send_word(OP_SAMPLE, 8'd255);
        send_word(OP_SAMPLE, 8'd0);
        send_word(OP_SAMPLE, 8'd255);
        send_word(OP_CROSS, 8'd0);
        send_word(OP_TAKE, 8'd255);
        send_word(OP_TAKE, 8'd0);
        send_word(OP_SAMPLE, 8'd128);
        send_word(OP_SAMPLE, 8'd128);
        send_word(OP_CROSS, 8'd0);
        send_word(OP_CROSS, 8'd0);
        send_word(OP_SAMPLE, 8'd170);
        send_word(OP_SAMPLE, 8'd85);
        send_word(OP_SOFT, 8'd0);
        send_word(OP_SAMPLE, 8'd1);
        send_word(OP_CROSS, 8'd0);

        for (phase = 0; phase < 10; phase++)
        begin
            wait_drained();
            case (phase)
                0: set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8);
                1: set_config(8'd255, 8'd255, 8'd255, 8'd7, 8'd7, 8'd255, 8'd255, 8'd255);
                2: set_config(8'd1, 8'd1, 8'd0, 8'd1, 8'd7, 8'd1, 8'd1, 8'd1);
                3: set_config(8'd3, 8'd2, 8'd4, 8'd3, 8'd4, 8'd2, 8'd3, 8'd0);
                default:
                    if ($urandom_range(0, 3) == 0)
                        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 7)),
                                   8'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    else
                        set_config(8'($urandom_range(0, 8)), 8'($urandom_range(1, 4)),
                                   8'($urandom_range(0, 20)), 8'($urandom_range(0, 7)),
                                   8'($urandom_range(0, 7)), 8'($urandom_range(0, 5)),
                                   8'($urandom_range(0, 5)), 8'($urandom_range(1, 16)));
            endcase
            if (phase == 5)
                long_hold_req = 1'b1;
            phase_end = words_sent + ((phase == 3) ? 40 : 150);
            while (words_sent < phase_end)
            begin
                if (loud_left == 0)
                begin
                    loud      = !loud;
                    loud_left = $urandom_range(1, 8);
                end
                loud_left--;
                positive = !positive;
                amp = loud ? $urandom_range(30, 127) : $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(0, (max_per_half > 14) ? 16 : max_per_half + 2);
                else
                    n = $urandom_range(2, 10);

                send_word(OP_CROSS, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                    send_word(OP_TAKE, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0)
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 39) == 0)
                    send_word(OP_SOFT, 8'($urandom_range(0, 255)));
                repeat (n)
                begin
                    dev   = $urandom_range(amp / 2, amp);
                    level = $urandom_range(0, 6);
                    level = level - 3 + (positive ? 128 + dev : 128 - dev);
                    if (level < 0)
                        level = 0;
                    if (level > 255)
                        level = 255;
                    send_word(OP_SAMPLE, level[7:0]);
                end
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
